// ===== src/crse_pkg.sv =====
// Package for the Catmull-Rom segment evaluator.
// Holds default widths, the request action codes, the operation and state codes,
// and the multiplier control type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crse_pkg;

  localparam int CoordWidthDef  = 24;
  localparam int TimeFracBitsDef = 16;

  // Action field of an input request.
  localparam logic ActPush = 1'b0;
  localparam logic ActEval = 1'b1;

  // One step of the per-coordinate schedule, in issue order.
  typedef enum logic [2:0] {
    OpD   = 3'd0,
    OpE   = 3'd1,
    OpF   = 3'd2,
    OpG   = 3'd3,
    OpH   = 3'd4,
    OpM   = 3'd5,
    OpN   = 3'd6,
    OpPos = 3'd7
  } op_e;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StLoad = 6'b000010,
    StPrep = 6'b000100,
    StMul  = 6'b001000,
    StPost = 6'b010000,
    StDone = 6'b100000
  } state_e;

  typedef struct packed {
    logic en;
    logic add_half;
  } mul_ctrl_t;

endpackage

`default_nettype wire

// ===== src/crse_if.sv =====
// Valid/ready channel interfaces for the Catmull-Rom segment evaluator.
// Depends on crse_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

interface crse_in_if
  import crse_pkg::*;
#(
  parameter int COORD_WIDTH    = CoordWidthDef,
  parameter int TIME_FRAC_BITS = TimeFracBitsDef
) ();
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic signed [COORD_WIDTH-1:0]    point_x;
  logic signed [COORD_WIDTH-1:0]    point_y;
  logic signed [COORD_WIDTH-1:0]    point_z;
  logic        [TIME_FRAC_BITS-1:0] eval_time;

  modport source (output valid, action, point_x, point_y, point_z, eval_time,
                  input ready);
  modport sink (input valid, action, point_x, point_y, point_z, eval_time,
                output ready);
endinterface

interface crse_out_if
  import crse_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidthDef
) ();
  logic                            valid;
  logic                            ready;
  logic signed [COORD_WIDTH-1:0]   pos_x;
  logic signed [COORD_WIDTH-1:0]   pos_y;
  logic signed [COORD_WIDTH-1:0]   pos_z;
  logic signed [COORD_WIDTH+3:0]   slope_x;
  logic signed [COORD_WIDTH+3:0]   slope_y;
  logic signed [COORD_WIDTH+3:0]   slope_z;

  modport source (output valid, pos_x, pos_y, pos_z, slope_x, slope_y, slope_z,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, slope_x, slope_y, slope_z,
                output ready);
endinterface

`default_nettype wire

// ===== src/crse_window.sv =====
// Four-point control window, three coordinates per point, shifted on each push.
// Presents the four points of one selected coordinate. Depends on crse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crse_window
  import crse_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_z_i,
  input  wire logic        [1:0]             coord_i,
  output logic signed [COORD_WIDTH-1:0]      p0_o,
  output logic signed [COORD_WIDTH-1:0]      p1_o,
  output logic signed [COORD_WIDTH-1:0]      p2_o,
  output logic signed [COORD_WIDTH-1:0]      p3_o
);

  logic signed [COORD_WIDTH-1:0] x_q [4];
  logic signed [COORD_WIDTH-1:0] y_q [4];
  logic signed [COORD_WIDTH-1:0] z_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        x_q[i] <= '0;
        y_q[i] <= '0;
        z_q[i] <= '0;
      end
    end else if (push_i) begin
      for (int i = 0; i < 3; i++) begin
        x_q[i] <= x_q[i+1];
        y_q[i] <= y_q[i+1];
        z_q[i] <= z_q[i+1];
      end
      x_q[3] <= point_x_i;
      y_q[3] <= point_y_i;
      z_q[3] <= point_z_i;
    end
  end

  always_comb begin
    case (coord_i)
      2'd0: begin
        p0_o = x_q[0];
        p1_o = x_q[1];
        p2_o = x_q[2];
        p3_o = x_q[3];
      end
      2'd1: begin
        p0_o = y_q[0];
        p1_o = y_q[1];
        p2_o = y_q[2];
        p3_o = y_q[3];
      end
      default: begin
        p0_o = z_q[0];
        p1_o = z_q[1];
        p2_o = z_q[2];
        p3_o = z_q[3];
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/crse_mul.sv =====
// Shared multiply-accumulate unit: signed operand times unsigned operand,
// with an optional rounding constant, into one product register. Depends on crse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crse_mul
  import crse_pkg::*;
#(
  parameter int A_WIDTH        = 27,
  parameter int B_WIDTH        = 27,
  parameter int TIME_FRAC_BITS = TimeFracBitsDef
) (
  input  wire logic                                clk_i,
  input  wire mul_ctrl_t                           ctrl_i,
  input  wire logic signed [A_WIDTH-1:0]           a_i,
  input  wire logic        [B_WIDTH-1:0]           b_i,
  output logic signed [A_WIDTH+B_WIDTH:0]          prod_o
);

  localparam int PW = A_WIDTH + B_WIDTH + 1;
  localparam logic signed [PW-1:0] Half = PW'(1) << (TIME_FRAC_BITS - 1);

  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] prod_d;
  logic signed [B_WIDTH:0] b_ext;

  assign b_ext  = $signed({1'b0, b_i});
  assign prod_d = PW'(a_i) * PW'(b_ext) + (ctrl_i.add_half ? Half : '0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== src/catmull_rom_segment_evaluator.sv =====
// Top level of the Catmull-Rom segment evaluator: sequencer, scratch registers,
// output register. Depends on crse_pkg, crse_if, crse_window and crse_mul.
//
//  Channel | Dir | Payload                                       | Request
//  in_i    | in  | action, point_x/y/z, eval_time                | push or evaluate
//  out_o   | out | pos_x/y/z, slope_x/y/z                        | evaluate result
//
// A push only shifts the control window; the sequencer stays idle. An evaluate runs, per
// coordinate, two divide-by-six steps (load, prepare, multiply, post) and six interpolation
// steps (load, multiply, post), all through the one shared multiplier, then a handoff.
// Reset clears the control window to zero. The input is taken only while the sequencer
// is idle; a finished result waits in the output register while new requests are taken.
`timescale 1ns / 1ps
`default_nettype none

module catmull_rom_segment_evaluator
  import crse_pkg::*;
#(
  parameter int COORD_WIDTH    = CoordWidthDef,
  parameter int TIME_FRAC_BITS = TimeFracBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  crse_in_if.sink    in_i,
  crse_out_if.source out_o
);

  localparam int W   = COORD_WIDTH;
  localparam int T   = TIME_FRAC_BITS;
  localparam int IW  = W + 2;
  localparam int DW  = IW + 1;
  localparam int SW  = W + 4;
  localparam int K   = W + 5;
  localparam int RW  = W + 3;
  localparam int BW  = (T > RW) ? T : RW;
  localparam int PW  = DW + BW + 1;
  localparam logic [63:0] Recip64 = ((64'd1 << K) + 64'd5) / 64'd6;
  localparam logic [BW-1:0] Recip = BW'(Recip64);
  localparam logic signed [DW-1:0] PosMax = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [DW-1:0] PosMin = {{(DW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [DW+1:0] SlMax = {{(DW+3-SW){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [DW+1:0] SlMin = {{(DW+3-SW){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [DW-1:0] Three = DW'(3);

  state_e state_q, state_d;
  op_e    op_q;
  logic [1:0] coord_q;
  logic [T-1:0] t_q;
  logic signed [DW-1:0] diff_q;
  logic signed [IW-1:0] base_q;
  logic signed [DW-1:0] mag_q;
  logic neg_q;
  logic signed [IW-1:0] d_q, e_q, f_q, g_q, h_q, m_q, n_q;
  logic signed [W-1:0]  wpos_q [3];
  logic signed [SW-1:0] wslope_q [3];
  logic signed [W-1:0]  opos_q [3];
  logic signed [SW-1:0] oslope_q [3];
  logic out_valid_q;

  logic in_acc, push_en, eval_start, is_div, handoff;
  logic signed [W-1:0] p0, p1, p2, p3;
  logic signed [IW-1:0] p0e, p1e, p2e, p3e, a_sel, b_sel, base_sel;
  logic signed [DW-1:0] diff_d;
  mul_ctrl_t mul_ctrl;
  logic signed [DW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic [IW-1:0] quot;
  logic div_sub;
  logic signed [DW-1:0] base_ext, div_res, lerp_sh, lerp_res;
  logic signed [DW+1:0] slope3;
  logic signed [W-1:0] pos_sat;
  logic signed [SW-1:0] slope_sat;

  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign push_en    = in_acc && (in_i.action == ActPush);
  assign eval_start = in_acc && (in_i.action == ActEval);
  assign is_div     = op_q inside {OpD, OpE};
  assign handoff    = (state_q == StDone) && (!out_valid_q || out_o.ready);

  crse_window #(
    .COORD_WIDTH(W)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_en),
    .point_x_i(in_i.point_x),
    .point_y_i(in_i.point_y),
    .point_z_i(in_i.point_z),
    .coord_i  (coord_q),
    .p0_o     (p0),
    .p1_o     (p1),
    .p2_o     (p2),
    .p3_o     (p3)
  );

  assign p0e = IW'(p0);
  assign p1e = IW'(p1);
  assign p2e = IW'(p2);
  assign p3e = IW'(p3);

  always_comb begin
    case (op_q)
      OpD: begin
        a_sel = p0e;  b_sel = p2e;  base_sel = p1e;
      end
      OpE: begin
        a_sel = p1e;  b_sel = p3e;  base_sel = p2e;
      end
      OpF: begin
        a_sel = p1e;  b_sel = d_q;  base_sel = p1e;
      end
      OpG: begin
        a_sel = d_q;  b_sel = e_q;  base_sel = d_q;
      end
      OpH: begin
        a_sel = e_q;  b_sel = p2e;  base_sel = e_q;
      end
      OpM: begin
        a_sel = f_q;  b_sel = g_q;  base_sel = f_q;
      end
      OpN: begin
        a_sel = g_q;  b_sel = h_q;  base_sel = g_q;
      end
      default: begin
        a_sel = m_q;  b_sel = n_q;  base_sel = m_q;
      end
    endcase
  end

  assign diff_d = DW'(b_sel) - DW'(a_sel);

  assign mul_ctrl.en       = (state_q == StMul);
  assign mul_ctrl.add_half = !is_div;
  assign mul_a = is_div ? mag_q : diff_q;
  assign mul_b = is_div ? Recip : BW'(t_q);

  crse_mul #(
    .A_WIDTH       (DW),
    .B_WIDTH       (BW),
    .TIME_FRAC_BITS(T)
  ) u_mul (
    .clk_i (clk_i),
    .ctrl_i(mul_ctrl),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  assign base_ext = DW'(base_q);
  assign quot     = prod[K +: IW];
  assign div_sub  = neg_q ^ (op_q == OpE);
  assign div_res  = div_sub ? (base_ext - $signed({1'b0, quot}))
                            : (base_ext + $signed({1'b0, quot}));
  assign lerp_sh  = prod[T +: DW];
  assign lerp_res = base_ext + lerp_sh;
  assign slope3   = (DW+2)'(diff_q) + ((DW+2)'(diff_q) <<< 1);

  always_comb begin
    if (lerp_res > PosMax) begin
      pos_sat = PosMax[W-1:0];
    end else if (lerp_res < PosMin) begin
      pos_sat = PosMin[W-1:0];
    end else begin
      pos_sat = lerp_res[W-1:0];
    end
    if (slope3 > SlMax) begin
      slope_sat = SlMax[SW-1:0];
    end else if (slope3 < SlMin) begin
      slope_sat = SlMin[SW-1:0];
    end else begin
      slope_sat = slope3[SW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (eval_start) begin
          state_d = StLoad;
        end
      end
      StLoad: state_d = is_div ? StPrep : StMul;
      StPrep: state_d = StMul;
      StMul:  state_d = StPost;
      StPost: begin
        if (op_q != OpPos) begin
          state_d = StLoad;
        end else if (coord_q == 2'd2) begin
          state_d = StDone;
        end else begin
          state_d = StLoad;
        end
      end
      StDone: begin
        if (handoff) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= OpD;
      coord_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (eval_start) begin
        op_q    <= OpD;
        coord_q <= '0;
      end else if (state_q == StPost) begin
        if (op_q == OpPos) begin
          op_q    <= OpD;
          coord_q <= (coord_q == 2'd2) ? coord_q : coord_q + 2'd1;
        end else begin
          op_q <= op_e'(op_q + 3'd1);
        end
      end
      if (handoff) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_start) begin
      t_q <= in_i.eval_time;
    end
    if (state_q == StLoad) begin
      diff_q <= diff_d;
      base_q <= base_sel;
    end
    if (state_q == StPrep) begin
      neg_q <= diff_q[DW-1];
      mag_q <= diff_q[DW-1] ? (Three - diff_q) : (diff_q + Three);
    end
    if (state_q == StPost) begin
      case (op_q)
        OpD: d_q <= div_res[IW-1:0];
        OpE: e_q <= div_res[IW-1:0];
        OpF: f_q <= lerp_res[IW-1:0];
        OpG: g_q <= lerp_res[IW-1:0];
        OpH: h_q <= lerp_res[IW-1:0];
        OpM: m_q <= lerp_res[IW-1:0];
        OpN: n_q <= lerp_res[IW-1:0];
        default: begin
          wpos_q[coord_q]   <= pos_sat;
          wslope_q[coord_q] <= slope_sat;
        end
      endcase
    end
    if (handoff) begin
      for (int i = 0; i < 3; i++) begin
        opos_q[i]   <= wpos_q[i];
        oslope_q[i] <= wslope_q[i];
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.pos_x   = opos_q[0];
  assign out_o.pos_y   = opos_q[1];
  assign out_o.pos_z   = opos_q[2];
  assign out_o.slope_x = oslope_q[0];
  assign out_o.slope_y = oslope_q[1];
  assign out_o.slope_z = oslope_q[2];

  a_eval_starts_schedule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_start |=> (state_q == StLoad) && (op_q == OpD) && (coord_q == 2'd0))
    else $error("evaluate request did not start the schedule at its first step");

  a_push_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en |=> (state_q == StIdle))
    else $error("push request left the sequencer busy");

  a_coord_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coord_q != 2'd3)
    else $error("coordinate counter ran past the last coordinate");

  a_handoff_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    handoff |=> out_valid_q && (state_q == StIdle))
    else $error("finished result was not presented on the output");

endmodule

`default_nettype wire

// ===== sim/crse_checker.sv =====
// Checker for the Catmull-Rom segment evaluator: tracks the control window, predicts each
// evaluate result and compares it with the output channel.
// Depends on crse_pkg and the channel interfaces in crse_if.
`timescale 1ns / 1ps

module crse_checker
  import crse_pkg::*;
#(
  parameter int COORD_WIDTH    = CoordWidthDef,
  parameter int TIME_FRAC_BITS = TimeFracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  crse_in_if   in_mon,
  crse_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int SlopeWidth = COORD_WIDTH + 4;

  typedef struct {
    longint pos[3];
    longint slope[3];
  } curve_sample_t;

  longint        ctrl_pts[4][3];
  curve_sample_t sample_q[$];
  curve_sample_t want;

  function automatic longint div_by_six(longint x);
    longint mag;
    longint q;
    mag = (x < 0) ? -x : x;
    q   = (mag + 3) / 6;
    return (x < 0) ? -q : q;
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + (((b - a) * t + (longint'(1) <<< (TIME_FRAC_BITS - 1))) >>> TIME_FRAC_BITS);
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Bezier control points from the Catmull-Rom window, then de Casteljau.
  function automatic void coord_curve(input longint p0, p1, p2, p3, t,
                                      output longint pos, output longint slope);
    longint d, e, f, g, h, m, n;
    d     = p1 + div_by_six(p2 - p0);
    e     = p2 - div_by_six(p3 - p1);
    f     = blend(p1, d, t);
    g     = blend(d, e, t);
    h     = blend(e, p2, t);
    m     = blend(f, g, t);
    n     = blend(g, h, t);
    pos   = blend(m, n, t);
    slope = 3 * (n - m);
  endfunction

  function automatic curve_sample_t eval_segment(longint t);
    curve_sample_t s;
    longint p;
    longint sl;
    for (int c = 0; c < 3; c++) begin
      coord_curve(ctrl_pts[0][c], ctrl_pts[1][c], ctrl_pts[2][c], ctrl_pts[3][c], t, p, sl);
      s.pos[c]   = clamp(p, COORD_WIDTH);
      s.slope[c] = clamp(sl, SlopeWidth);
    end
    return s;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (ctrl_pts[i, c]) ctrl_pts[i][c] = 0;
      sample_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (sample_q.size() == 0) begin
          $error("result arrived with no evaluate request outstanding");
          fail_count_o++;
        end else begin
          want = sample_q.pop_front();
          check_field("pos_x", want.pos[0], longint'(out_mon.pos_x));
          check_field("pos_y", want.pos[1], longint'(out_mon.pos_y));
          check_field("pos_z", want.pos[2], longint'(out_mon.pos_z));
          check_field("slope_x", want.slope[0], longint'(out_mon.slope_x));
          check_field("slope_y", want.slope[1], longint'(out_mon.slope_y));
          check_field("slope_z", want.slope[2], longint'(out_mon.slope_z));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == ActEval) begin
          sample_q.push_back(eval_segment(longint'(in_mon.eval_time)));
        end else begin
          ctrl_pts[0] = ctrl_pts[1];
          ctrl_pts[1] = ctrl_pts[2];
          ctrl_pts[2] = ctrl_pts[3];
          ctrl_pts[3][0] = longint'(in_mon.point_x);
          ctrl_pts[3][1] = longint'(in_mon.point_y);
          ctrl_pts[3][2] = longint'(in_mon.point_z);
        end
      end
      pending_o = sample_q.size();
    end
  end

endmodule

// ===== sim/tb_catmull_rom_segment_evaluator.sv =====
// Testbench top for the Catmull-Rom segment evaluator: clock, reset, push and evaluate
// requests with random idling on both channels, and the final verdict.
// Depends on crse_pkg, crse_if, the evaluator RTL and crse_checker.
`timescale 1ns / 1ps

module tb_catmull_rom_segment_evaluator
  import crse_pkg::*;
();

  localparam int CW = CoordWidthDef;
  localparam int TF = TimeFracBitsDef;

  localparam logic signed [CW-1:0] CoordMax = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] CoordMin = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [TF-1:0]        TimeMax  = '1;
  localparam logic [TF-1:0]        TimeHalf = {1'b1, {(TF - 1){1'b0}}};

  localparam int IdlePct       = 38;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 100;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   jitter_on;
  int   idle_cycles = 0;
  int   fail_count;
  int   pending;

  crse_in_if  in_ch ();
  crse_out_if out_ch ();

  catmull_rom_segment_evaluator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  crse_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ch.ready <= jitter_on ? ($urandom_range(99) >= IdlePct) : 1'b1;
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [CW-1:0] rand_coord();
    logic signed [CW-1:0] v;
    case ($urandom_range(9))
      0: v = CoordMax;
      1: v = CoordMin;
      2, 3: begin
        v = CW'($urandom_range(2047));
        v = v - CW'(1024);
      end
      default: v = CW'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic [TF-1:0] rand_time();
    case ($urandom_range(7))
      0: return '0;
      1: return TimeMax;
      default: return TF'($urandom());
    endcase
  endfunction

  task automatic send_item(input logic act, input logic [CW-1:0] x, y, z,
                           input logic [TF-1:0] t);
    while (jitter_on && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.point_x   <= x;
    in_ch.point_y   <= y;
    in_ch.point_z   <= z;
    in_ch.eval_time <= t;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic push_point(input logic [CW-1:0] x, y, z);
    send_item(ActPush, x, y, z, rand_time());
  endtask

  task automatic evaluate_at(input logic [TF-1:0] t);
    send_item(ActEval, rand_coord(), rand_coord(), rand_coord(), t);
  endtask

  task automatic random_run(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(), rand_time());
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni          = 1'b0;
    jitter_on       = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.action    = ActPush;
    in_ch.point_x   = '0;
    in_ch.point_y   = '0;
    in_ch.point_z   = '0;
    in_ch.eval_time = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The window is partly empty for the first few evaluate requests.
    evaluate_at('0);
    evaluate_at(TimeMax);
    push_point(CoordMax, CoordMin, '0);
    evaluate_at(TimeHalf);
    push_point(CoordMin, CoordMax, CoordMax);
    evaluate_at(TF'(1));
    push_point(CoordMax, CoordMin, CoordMin);
    evaluate_at(TimeMax);
    // Alternating extremes swing the position across the full coordinate range.
    push_point(CoordMin, CoordMax, '0);
    evaluate_at('0);
    evaluate_at(16'h4000);
    evaluate_at(TimeHalf);
    evaluate_at(16'hC000);
    evaluate_at(TimeMax);
    push_point('1, CW'(1), '0);
    evaluate_at(TimeHalf);
    push_point('0, '1, CW'(1));
    evaluate_at(TimeMax);

    random_run(200);
    in_ch.valid <= 1'b0;
    wait_drained();
    jitter_on <= 1'b0;
    random_run(100);
    jitter_on <= 1'b1;
    random_run(130);
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
